FILE: rtl/qacm_pkg.sv
// ----------------------------------------------------------------------------
// qacm_pkg
// Shared types, constants and helper functions for the attitude control
// mixer pipeline.
// ----------------------------------------------------------------------------
package qacm_pkg;

  localparam int unsigned W            = 16;
  localparam int unsigned GAIN_W       = 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned NUM_MOTORS   = 4;
  localparam int unsigned SENSE_SHIFT  = 6;
  localparam int unsigned SQRT_STEPS   = 4;   // root iterations per stage
  localparam int unsigned SQRT_LO_SHFT = 2 * SQRT_STEPS;

  localparam logic [W-1:0]        SQRT_TOP    = 16'h4000;
  localparam logic signed [W-1:0] LIFT_MIN    = 16'sd277;
  localparam logic signed [W-1:0] MOTOR_MIN   = 16'sd200;
  localparam logic signed [W-1:0] MOTOR_MAX   = 16'sd600;
  localparam logic [3:0]          MOTOR_SCALE = 4'd3;

  typedef enum logic [1:0] {
    OP_MANUAL = 2'd0,
    OP_YAW    = 2'd1,
    OP_FULL   = 2'd2,
    OP_RAW    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_YAW_GAIN           = 3'd0,
    CFG_ANGLE_GAIN         = 3'd1,
    CFG_RATE_GAIN          = 3'd2,
    CFG_YAW_RATE_OFFSET    = 3'd3,
    CFG_ROLL_RATE_OFFSET   = 3'd4,
    CFG_PITCH_RATE_OFFSET  = 3'd5,
    CFG_ROLL_ANGLE_OFFSET  = 3'd6,
    CFG_PITCH_ANGLE_OFFSET = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    op_e                 op;
    logic signed [W-1:0] lift_set;
    logic signed [W-1:0] roll_set;
    logic signed [W-1:0] pitch_set;
    logic signed [W-1:0] yaw_set;
    logic signed [W-1:0] yaw_rate;
    logic signed [W-1:0] roll_rate;
    logic signed [W-1:0] pitch_rate;
    logic signed [W-1:0] roll_angle;
    logic signed [W-1:0] pitch_angle;
  } in_t;

  typedef struct packed {
    logic signed [W-1:0] motor_front;
    logic signed [W-1:0] motor_right;
    logic signed [W-1:0] motor_back;
    logic signed [W-1:0] motor_left;
  } out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] yaw_gain;
    logic [GAIN_W-1:0] angle_gain;
    logic [GAIN_W-1:0] rate_gain;
    logic [W-1:0]      yaw_rate_offset;
    logic [W-1:0]      roll_rate_offset;
    logic [W-1:0]      pitch_rate_offset;
    logic [W-1:0]      roll_angle_offset;
    logic [W-1:0]      pitch_angle_offset;
  } cfg_t;

  // after sensor scaling and offset removal
  typedef struct packed {
    op_e          op;
    logic [W-1:0] lift;
    logic [W-1:0] roll;
    logic [W-1:0] pitch;
    logic [W-1:0] yaw;     // setpoint in manual, yaw error otherwise
    logic [W-1:0] ang_r;
    logic [W-1:0] ang_p;
    logic [W-1:0] rt_r;
    logic [W-1:0] rt_p;
  } s1_t;

  // after gain products
  typedef s1_t s2_t;

  typedef struct packed {
    logic [W-1:0] root;
    logic [W-1:0] rem;
  } sq_lane_t;

  typedef struct packed {
    logic                            half;   // 0: upper root bits still to do
    logic                            clamp;  // normal lift: clamp to motor range
    sq_lane_t [NUM_MOTORS-1:0]       lane;
  } sq_t;

  function automatic logic [W-1:0] sense_scale(logic [W-1:0] x);
    return W'($signed(x) >>> SENSE_SHIFT);
  endfunction

  function automatic logic [W-1:0] mul_lo(logic [W-1:0] a, logic [GAIN_W-1:0] g);
    logic [W+GAIN_W-1:0] p;
    p = {{GAIN_W{1'b0}}, a} * {{W{1'b0}}, g};
    return p[W-1:0];
  endfunction

  // one restoring step of the bitwise integer square root
  function automatic sq_lane_t sqrt_step(sq_lane_t s, logic [W-1:0] bit_w);
    sq_lane_t    r;
    logic [W:0]  trial;
    trial  = {1'b0, s.root} + {1'b0, bit_w};
    r.root = s.root >> 1;
    r.rem  = s.rem;
    if (trial <= {1'b0, s.rem}) begin
      r.root = r.root + bit_w;
      r.rem  = s.rem - trial[W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/qacm_front.sv
// ----------------------------------------------------------------------------
// qacm_front
// Stage 1: sensor scaling, offset removal and error terms.
// ----------------------------------------------------------------------------
module qacm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  qacm_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  qacm_pkg::in_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output qacm_pkg::s1_t data_o
);
  import qacm_pkg::*;

  logic valid_q;
  s1_t  data_d, data_q;

  always_comb begin
    logic [W-1:0] yr, rr, pr, ra, pa;
    yr = sense_scale(data_i.yaw_rate);
    rr = sense_scale(data_i.roll_rate);
    pr = sense_scale(data_i.pitch_rate);
    ra = sense_scale(data_i.roll_angle);
    pa = sense_scale(data_i.pitch_angle);

    data_d.op    = data_i.op;
    data_d.lift  = data_i.lift_set;
    data_d.roll  = data_i.roll_set;
    data_d.pitch = data_i.pitch_set;
    data_d.yaw   = (data_i.op == OP_MANUAL) ? data_i.yaw_set
                 : data_i.yaw_set - (yr - cfg_i.yaw_rate_offset);
    if (data_i.op == OP_FULL) begin
      data_d.ang_r = data_i.roll_set  - (ra - cfg_i.roll_angle_offset);
      data_d.ang_p = data_i.pitch_set - (pa - cfg_i.pitch_angle_offset);
      data_d.rt_r  = rr - cfg_i.roll_rate_offset;
      data_d.rt_p  = pr - cfg_i.pitch_rate_offset;
    end else begin
      // raw estimates carry no offset
      data_d.ang_r = ra;
      data_d.ang_p = pa;
      data_d.rt_r  = rr;
      data_d.rt_p  = pr;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/qacm_gain.sv
// ----------------------------------------------------------------------------
// qacm_gain
// Stage 2: gain products for yaw, angle and rate terms.
// ----------------------------------------------------------------------------
module qacm_gain (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qacm_pkg::cfg_t cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  qacm_pkg::s1_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output qacm_pkg::s2_t  data_o
);
  import qacm_pkg::*;

  logic              valid_q;
  s2_t               data_d, data_q;
  logic [GAIN_W-1:0] ag;

  // full mode uses a quarter of the angle gain
  assign ag = (data_i.op == OP_FULL) ? {2'b00, cfg_i.angle_gain[GAIN_W-1:2]}
                                     : cfg_i.angle_gain;

  always_comb begin
    data_d       = data_i;
    data_d.yaw   = (data_i.op == OP_MANUAL) ? data_i.yaw
                 : mul_lo(data_i.yaw, cfg_i.yaw_gain);
    data_d.ang_r = mul_lo(data_i.ang_r, ag);
    data_d.ang_p = mul_lo(data_i.ang_p, ag);
    data_d.rt_r  = mul_lo(data_i.rt_r, cfg_i.rate_gain);
    data_d.rt_p  = mul_lo(data_i.rt_p, cfg_i.rate_gain);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/qacm_mix.sv
// ----------------------------------------------------------------------------
// qacm_mix
// Stage 3: roll/pitch correction and quad-X motor mixing.
// ----------------------------------------------------------------------------
module qacm_mix (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  qacm_pkg::s2_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output qacm_pkg::sq_t data_o
);
  import qacm_pkg::*;

  logic         valid_q;
  sq_t          data_d, data_q;
  logic [W-1:0] roll_f, pitch_f, roll2, pitch2;
  logic         low_lift;

  always_comb begin
    unique case (data_i.op)
      OP_FULL: begin
        roll_f  = data_i.ang_r - data_i.rt_r;
        pitch_f = data_i.ang_p + data_i.rt_p;
      end
      OP_RAW: begin
        roll_f  = data_i.roll  - data_i.ang_r - data_i.rt_r;
        pitch_f = data_i.pitch - data_i.ang_p + data_i.rt_p;
      end
      default: begin
        roll_f  = data_i.roll;
        pitch_f = data_i.pitch;
      end
    endcase
  end

  assign roll2    = {roll_f[W-2:0], 1'b0};
  assign pitch2   = {pitch_f[W-2:0], 1'b0};
  assign low_lift = $signed(data_i.lift) < LIFT_MIN;

  always_comb begin
    data_d.half  = 1'b0;
    data_d.clamp = !low_lift;
    for (int l = 0; l < NUM_MOTORS; l++) begin
      data_d.lane[l].root = '0;
    end
    if (low_lift) begin
      for (int l = 0; l < NUM_MOTORS; l++) begin
        data_d.lane[l].rem = data_i.lift;
      end
    end else begin
      data_d.lane[0].rem = data_i.lift - data_i.yaw + pitch2;   // front
      data_d.lane[1].rem = data_i.lift + data_i.yaw - roll2;    // right
      data_d.lane[2].rem = data_i.lift - data_i.yaw - pitch2;   // back
      data_d.lane[3].rem = data_i.lift + data_i.yaw + roll2;    // left
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/qacm_sqrt.sv
// ----------------------------------------------------------------------------
// qacm_sqrt
// Half of the integer square root: four restoring steps per motor lane.
// The first instance also takes the magnitude.
// ----------------------------------------------------------------------------
module qacm_sqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  qacm_pkg::sq_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output qacm_pkg::sq_t data_o
);
  import qacm_pkg::*;

  logic valid_q;
  sq_t  data_d, data_q;

  always_comb begin
    sq_lane_t     cur;
    logic [W-1:0] top_w;
    logic [W-1:0] bit_w;
    data_d      = data_i;
    data_d.half = 1'b1;
    top_w       = data_i.half ? (SQRT_TOP >> SQRT_LO_SHFT) : SQRT_TOP;
    for (int l = 0; l < NUM_MOTORS; l++) begin
      cur = data_i.lane[l];
      // magnitude; 0x8000 maps to itself, i.e. 32768
      if (!data_i.half && cur.rem[W-1]) begin
        cur.rem = ~cur.rem + 1'b1;
      end
      for (int k = 0; k < SQRT_STEPS; k++) begin
        bit_w = top_w >> (2 * k);
        cur   = sqrt_step(cur, bit_w);
      end
      data_d.lane[l] = cur;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/quadrotor_attitude_control_mixer_top.sv
// ----------------------------------------------------------------------------
// quadrotor_attitude_control_mixer_top
// Proportional attitude controller and quad-X motor mixer, six-stage pipeline.
// ----------------------------------------------------------------------------
// Usage: one control sample enters per cycle when in_ready_o is high, and its
// four motor commands reach out_data_o through six register stages (sensor
// scaling and errors, gain products, mixer, two square-root halves, motor
// scale and clamp). Each stage holds one transaction with its own valid bit;
// a stage takes a new one whenever it is empty or its successor takes its
// current one, so bubbles close up and the input keeps flowing while a result
// waits on the output, until all six stages are full. The square root is
// split over two stages of four restoring steps each. Gains and offsets are
// written through the cfg port (always ready); the user must write them only
// while no transaction is in flight, as the block itself does not enforce it.
// All reset to zero.
// ----------------------------------------------------------------------------
module quadrotor_attitude_control_mixer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [qacm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [qacm_pkg::W-1:0]           cfg_data_i,
  // control samples in
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  qacm_pkg::in_t                    in_data_i,
  // motor commands out
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output qacm_pkg::out_t                   out_data_o
);
  import qacm_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_YAW_GAIN:           cfg_d.yaw_gain           = cfg_data_i[GAIN_W-1:0];
        CFG_ANGLE_GAIN:         cfg_d.angle_gain         = cfg_data_i[GAIN_W-1:0];
        CFG_RATE_GAIN:          cfg_d.rate_gain          = cfg_data_i[GAIN_W-1:0];
        CFG_YAW_RATE_OFFSET:    cfg_d.yaw_rate_offset    = cfg_data_i;
        CFG_ROLL_RATE_OFFSET:   cfg_d.roll_rate_offset   = cfg_data_i;
        CFG_PITCH_RATE_OFFSET:  cfg_d.pitch_rate_offset  = cfg_data_i;
        CFG_ROLL_ANGLE_OFFSET:  cfg_d.roll_angle_offset  = cfg_data_i;
        CFG_PITCH_ANGLE_OFFSET: cfg_d.pitch_angle_offset = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline stages
  // --------------------------------------------------------------------------
  logic s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;
  logic s4_valid, s4_ready, s5_valid, s5_ready;
  s1_t  s1_data;
  s2_t  s2_data;
  sq_t  s3_data, s4_data, s5_data;

  qacm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  qacm_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  qacm_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  // upper four root bits, magnitude first
  qacm_sqrt u_sqrt_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .data_i  (s3_data),
    .valid_o (s4_valid),
    .ready_i (s4_ready),
    .data_o  (s4_data)
  );

  // lower four root bits
  qacm_sqrt u_sqrt_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_valid),
    .ready_o (s4_ready),
    .data_i  (s4_data),
    .valid_o (s5_valid),
    .ready_i (s5_ready),
    .data_o  (s5_data)
  );

  // --------------------------------------------------------------------------
  // Output stage: scale root by motor constant, clamp on normal lift
  // --------------------------------------------------------------------------
  logic                                 out_valid_q;
  logic                                 out_clamp_q;
  logic [NUM_MOTORS-1:0][W-1:0]         motor_d;
  out_t                                 out_data_q;

  always_comb begin
    logic [W+3:0]        prod;
    logic signed [W-1:0] m;
    for (int l = 0; l < NUM_MOTORS; l++) begin
      prod = s5_data.lane[l].root * MOTOR_SCALE;
      m    = signed'(prod[W-1:0]);
      if (s5_data.clamp) begin
        if (m < MOTOR_MIN) begin
          m = MOTOR_MIN;
        end
        if (m > MOTOR_MAX) begin
          m = MOTOR_MAX;
        end
      end
      motor_d[l] = m;
    end
  end

  assign s5_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s5_ready) begin
      out_valid_q <= s5_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_valid && s5_ready) begin
      out_data_q.motor_front <= motor_d[0];
      out_data_q.motor_right <= motor_d[1];
      out_data_q.motor_back  <= motor_d[2];
      out_data_q.motor_left  <= motor_d[3];
      out_clamp_q            <= s5_data.clamp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // every command lies in 0..600 (root of 32768 times 3 stays below 600)
  a_motor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.motor_front >= 0) && (out_data_o.motor_front <= MOTOR_MAX)
                 && (out_data_o.motor_right >= 0) && (out_data_o.motor_right <= MOTOR_MAX)
                 && (out_data_o.motor_back  >= 0) && (out_data_o.motor_back  <= MOTOR_MAX)
                 && (out_data_o.motor_left  >= 0) && (out_data_o.motor_left  <= MOTOR_MAX))
    else $error("motor command out of range");

  // normal lift commands respect the lower clamp
  a_clamp_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_clamp_q |-> (out_data_o.motor_front >= MOTOR_MIN)
                                && (out_data_o.motor_right >= MOTOR_MIN)
                                && (out_data_o.motor_back  >= MOTOR_MIN)
                                && (out_data_o.motor_left  >= MOTOR_MIN))
    else $error("clamped motor below minimum");

  // low lift drives all four motors alike
  a_low_lift_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_clamp_q |-> (out_data_o.motor_front == out_data_o.motor_right)
                                 && (out_data_o.motor_front == out_data_o.motor_back)
                                 && (out_data_o.motor_front == out_data_o.motor_left))
    else $error("low lift motors differ");

  // with the output free, no stage can hold back the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule
